@@ src/mbfd_pkg.sv @@
// Shared types, constants and output rounding for the binaural FIR decoder.
`timescale 1ns / 1ps
`default_nettype none
package mbfd_pkg;

  localparam int CHANNELS = 4;
  localparam int MAX_TAPS = 256;
  localparam int SAMPLE_W = 16;
  localparam int CH_W     = 2;
  localparam int TAP_W    = 8;
  localparam int FL_W     = 9;
  localparam int ACC_W    = 48;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int POS_W    = $clog2(MAX_TAPS);
  localparam int CA_W     = $clog2(CHANNELS * MAX_TAPS);
  localparam int Q_W      = ACC_W - SAMPLE_W + 2;

  typedef enum logic [0:0] {
    CMD_SAMPLE = 1'b0,
    CMD_COEF   = 1'b1
  } cmd_e;

  typedef enum logic [0:0] {
    EAR_LEFT  = 1'b0,
    EAR_RIGHT = 1'b1
  } ear_e;

  typedef struct packed {
    cmd_e                        cmd;
    ear_e                        ear;
    logic [CH_W-1:0]             channel;
    logic [TAP_W-1:0]            tap;
    logic signed [SAMPLE_W-1:0]  value;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_WRITE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  // Round half up to Q1.15, then saturate.
  function automatic logic [SAMPLE_W-1:0] sat_round(input logic [ACC_W-1:0] acc);
    logic [ACC_W:0]     s;
    logic [Q_W-1:0]     q;
    logic [SAMPLE_W-1:0] res;
    s = {acc[ACC_W-1], acc} + (ACC_W+1)'(1 << (SAMPLE_W - 2));
    q = s[ACC_W:SAMPLE_W-1];
    if ((&q[Q_W-1:SAMPLE_W-1]) || !(|q[Q_W-1:SAMPLE_W-1])) begin
      res = q[SAMPLE_W-1:0];
    end else if (q[Q_W-1]) begin
      res = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ src/mbfd_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module mbfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

@@ src/mbfd_front.sv @@
// Input side: accept beats, drop out-of-range items, queue the rest.
`timescale 1ns / 1ps
`default_nettype none
module mbfd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_stall_o,
  input  wire mbfd_pkg::item_t in_item_i,
  output      logic          q_valid_o,
  output      mbfd_pkg::item_t q_item_o,
  input  wire logic          q_pop_i
);

  mbfd_pkg::item_t slot_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;
  logic            accept, keep, bad_ch, bad_tap;

  assign in_stall_o = (count_q == 2'd2);
  assign accept     = in_valid_i && !in_stall_o;
  assign bad_ch     = {1'b0, in_item_i.channel} >= (mbfd_pkg::CH_W+1)'(mbfd_pkg::CHANNELS);
  assign bad_tap    = (in_item_i.cmd == mbfd_pkg::CMD_COEF) &&
                      ({1'b0, in_item_i.tap} >= (mbfd_pkg::TAP_W+1)'(mbfd_pkg::MAX_TAPS));
  assign keep       = accept && !bad_ch && !bad_tap;

  assign q_valid_o  = (count_q != 2'd0);
  assign q_item_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (keep) begin
      slot_q[wr_ptr_q] <= in_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (keep) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      // Hold count when one beat enters and one leaves.
      if (keep && !q_pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (!keep && q_pop_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/mbfd_back.sv @@
// Execution side: coefficient writes, delay-line clear, tap MAC loop, output register.
`timescale 1ns / 1ps
`default_nettype none
module mbfd_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mbfd_pkg::FL_W-1:0]     cfg_data_i,
  input  wire logic                          q_valid_i,
  input  wire mbfd_pkg::item_t               q_item_i,
  output      logic                          q_pop_o,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic [mbfd_pkg::SAMPLE_W-1:0] left_o,
  output      logic [mbfd_pkg::SAMPLE_W-1:0] right_o
);

  localparam int SW = mbfd_pkg::SAMPLE_W;
  localparam int PW = mbfd_pkg::PROD_W;
  localparam int AW = mbfd_pkg::ACC_W;

  mbfd_pkg::state_e state_q, state_d;
  mbfd_pkg::item_t  item_q;

  logic [mbfd_pkg::FL_W-1:0]  fl_q, n_taps, n_q;
  logic [mbfd_pkg::POS_W-1:0] wp_q, wp_eff, pos_q, cnt_q, last_pos;
  logic                       dirty_q, s1_q, s2_q, out_valid_q;
  logic [AW-1:0]              acc_l_q, acc_r_q;
  logic signed [PW-1:0]       prod_l_q, prod_r_q;
  logic [SW-1:0]              left_q, right_q;

  logic                       last_ch, out_free, head_coef;
  logic                       coef_wl, coef_wr, issue, load_out;
  logic [mbfd_pkg::CA_W-1:0]  coef_addr;
  logic [mbfd_pkg::POS_W-1:0] dly_addr;
  logic [SW-1:0]              coef_l_rd, coef_r_rd, dly_sel;
  logic [SW-1:0]              dly_rd [mbfd_pkg::CHANNELS];

  assign n_taps   = (fl_q > mbfd_pkg::FL_W'(mbfd_pkg::MAX_TAPS)) ?
                    mbfd_pkg::FL_W'(mbfd_pkg::MAX_TAPS) : fl_q;
  assign last_pos = mbfd_pkg::POS_W'(n_taps - mbfd_pkg::FL_W'(1));
  assign wp_eff   = ({1'b0, wp_q} >= n_taps) ? '0 : wp_q;
  assign last_ch  = item_q.channel == mbfd_pkg::CH_W'(mbfd_pkg::CHANNELS - 1);
  assign out_free = !out_valid_q || !out_stall_i;
  assign head_coef = q_item_i.cmd == mbfd_pkg::CMD_COEF;

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    coef_wl  = 1'b0;
    coef_wr  = 1'b0;
    issue    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      mbfd_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (head_coef) begin
            coef_wl = (q_item_i.ear == mbfd_pkg::EAR_LEFT);
            coef_wr = (q_item_i.ear == mbfd_pkg::EAR_RIGHT);
          end else if (n_taps == '0) begin
            if (q_item_i.channel == mbfd_pkg::CH_W'(mbfd_pkg::CHANNELS - 1)) begin
              state_d = mbfd_pkg::ST_FINISH;
            end
          end else begin
            state_d = dirty_q ? mbfd_pkg::ST_CLEAR : mbfd_pkg::ST_WRITE;
          end
        end
      end
      mbfd_pkg::ST_CLEAR: begin
        if (cnt_q == mbfd_pkg::POS_W'(mbfd_pkg::MAX_TAPS - 1)) begin
          state_d = mbfd_pkg::ST_WRITE;
        end
      end
      mbfd_pkg::ST_WRITE: begin
        state_d = mbfd_pkg::ST_MAC;
      end
      mbfd_pkg::ST_MAC: begin
        issue = 1'b1;
        if (n_q == n_taps - mbfd_pkg::FL_W'(1)) begin
          state_d = mbfd_pkg::ST_DRAIN;
        end
      end
      mbfd_pkg::ST_DRAIN: begin
        if (!s1_q && !s2_q) begin
          state_d = last_ch ? mbfd_pkg::ST_FINISH : mbfd_pkg::ST_IDLE;
        end
      end
      mbfd_pkg::ST_FINISH: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = mbfd_pkg::ST_IDLE;
        end
      end
      default: state_d = mbfd_pkg::ST_IDLE;
    endcase
  end

  // Coefficient rows: address is channel * MAX_TAPS + tap.
  assign coef_addr = (state_q == mbfd_pkg::ST_MAC) ?
    ((mbfd_pkg::CA_W'(item_q.channel) << mbfd_pkg::POS_W) |
      mbfd_pkg::CA_W'(n_q[mbfd_pkg::POS_W-1:0])) :
    ((mbfd_pkg::CA_W'(q_item_i.channel) << mbfd_pkg::POS_W) |
      mbfd_pkg::CA_W'(q_item_i.tap));

  assign dly_addr = (state_q == mbfd_pkg::ST_CLEAR) ? cnt_q :
                    (state_q == mbfd_pkg::ST_WRITE) ? wp_eff : pos_q;

  mbfd_ram #(.WIDTH(SW), .DEPTH(mbfd_pkg::CHANNELS * mbfd_pkg::MAX_TAPS)) u_coef_l (
    .clk_i   (clk_i),
    .we_i    (coef_wl),
    .addr_i  (coef_addr),
    .wdata_i (q_item_i.value),
    .rdata_o (coef_l_rd)
  );

  mbfd_ram #(.WIDTH(SW), .DEPTH(mbfd_pkg::CHANNELS * mbfd_pkg::MAX_TAPS)) u_coef_r (
    .clk_i   (clk_i),
    .we_i    (coef_wr),
    .addr_i  (coef_addr),
    .wdata_i (q_item_i.value),
    .rdata_o (coef_r_rd)
  );

  for (genvar c = 0; c < mbfd_pkg::CHANNELS; c++) begin : g_dly
    logic dly_we;
    assign dly_we = (state_q == mbfd_pkg::ST_CLEAR) ||
                    ((state_q == mbfd_pkg::ST_WRITE) &&
                     (item_q.channel == mbfd_pkg::CH_W'(c)));
    mbfd_ram #(.WIDTH(SW), .DEPTH(mbfd_pkg::MAX_TAPS)) u_dly (
      .clk_i   (clk_i),
      .we_i    (dly_we),
      .addr_i  (dly_addr),
      .wdata_i ((state_q == mbfd_pkg::ST_CLEAR) ? '0 : item_q.value),
      .rdata_o (dly_rd[c])
    );
  end

  assign dly_sel = dly_rd[item_q.channel];

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_item_i;
    end
    prod_l_q <= $signed(coef_l_rd) * $signed(dly_sel);
    prod_r_q <= $signed(coef_r_rd) * $signed(dly_sel);
    if (load_out) begin
      left_q  <= mbfd_pkg::sat_round(acc_l_q);
      right_q <= mbfd_pkg::sat_round(acc_r_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbfd_pkg::ST_IDLE;
      fl_q        <= '0;
      wp_q        <= '0;
      pos_q       <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      dirty_q     <= 1'b1;
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
      acc_l_q     <= '0;
      acc_r_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      s1_q    <= issue;
      s2_q    <= s1_q;
      if (cfg_we_i) begin
        fl_q    <= cfg_data_i;
        dirty_q <= 1'b1;
        wp_q    <= '0;
      end
      if (coef_wl || coef_wr) begin
        dirty_q <= 1'b1;
        wp_q    <= '0;
      end
      if (state_q == mbfd_pkg::ST_CLEAR) begin
        cnt_q <= cnt_q + mbfd_pkg::POS_W'(1);
        if (cnt_q == mbfd_pkg::POS_W'(mbfd_pkg::MAX_TAPS - 1)) begin
          dirty_q <= 1'b0;
        end
      end
      if (state_q == mbfd_pkg::ST_WRITE) begin
        wp_q  <= wp_eff;
        pos_q <= wp_eff;
        n_q   <= '0;
      end
      if (issue) begin
        pos_q <= (pos_q == '0) ? last_pos : pos_q - mbfd_pkg::POS_W'(1);
        n_q   <= n_q + mbfd_pkg::FL_W'(1);
      end
      if (s2_q) begin
        acc_l_q <= acc_l_q + {{(AW-PW){prod_l_q[PW-1]}}, prod_l_q};
        acc_r_q <= acc_r_q + {{(AW-PW){prod_r_q[PW-1]}}, prod_r_q};
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
        acc_l_q     <= '0;
        acc_r_q     <= '0;
        if (n_taps != '0) begin
          wp_q <= ({1'b0, wp_q} + mbfd_pkg::FL_W'(1) == n_taps) ?
                  '0 : wp_q + mbfd_pkg::POS_W'(1);
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign left_o      = left_q;
  assign right_o     = right_q;

endmodule
`default_nettype wire

@@ src/multichannel_binaural_fir_decoder_top.sv @@
// Top level of the ambisonic-to-binaural FIR decoder.
//
// Input channel: in_valid_i / in_stall_o carry one beat of cmd, ear, channel, tap, value.
// A coefficient beat (cmd 1) writes one left or right tap of a channel and marks the
// delay lines for clearing. A sample beat (cmd 0) stores the channel's sample and
// adds min(filter_length, 256) dual multiply-accumulates to the running ear sums; the beat on
// the last channel emits one output beat of left_o / right_o (Q1.15, saturated).
// Config: cfg_we_i writes filter_length; write it only while the block is idle.
// Timing: a front queue of two beats takes input while the back works. A sample's
// cost is set by the single MAC pass over the taps (one tap per cycle from the
// coefficient and delay RAMs). The first sample after reset, a config write or a
// coefficient write adds a delay-line clear. The back writes a coefficient beat in
// the cycle that it pops it and stays idle.
// Reset: sums, write position and filter_length go to zero, delay lines are marked
// for clearing; coefficients stay undefined until written.
// Output stall: the result holds in the output register; the back waits on it only
// when it has the next frame ready, and input backs up once the queue is full.
`timescale 1ns / 1ps
`default_nettype none
module multichannel_binaural_fir_decoder_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [mbfd_pkg::FL_W-1:0]           cfg_data_i,
  input  wire logic                                in_valid_i,
  output      logic                                in_stall_o,
  input  wire logic                                cmd_i,
  input  wire logic                                ear_i,
  input  wire logic [mbfd_pkg::CH_W-1:0]           channel_i,
  input  wire logic [mbfd_pkg::TAP_W-1:0]          tap_i,
  input  wire logic signed [mbfd_pkg::SAMPLE_W-1:0] value_i,
  output      logic                                out_valid_o,
  input  wire logic                                out_stall_i,
  output      logic signed [mbfd_pkg::SAMPLE_W-1:0] left_o,
  output      logic signed [mbfd_pkg::SAMPLE_W-1:0] right_o
);

  mbfd_pkg::item_t in_item, q_item;
  logic            q_valid, q_pop;
  logic [mbfd_pkg::SAMPLE_W-1:0] left_raw, right_raw;

  // Pack the beat fields into one queue entry.
  assign in_item.cmd     = mbfd_pkg::cmd_e'(cmd_i);
  assign in_item.ear     = mbfd_pkg::ear_e'(ear_i);
  assign in_item.channel = channel_i;
  assign in_item.tap     = tap_i;
  assign in_item.value   = value_i;

  mbfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  mbfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .left_o      (left_raw),
    .right_o     (right_raw)
  );

  assign left_o  = $signed(left_raw);
  assign right_o = $signed(right_raw);

endmodule
`default_nettype wire

@@ bench/tb_multichannel_binaural_fir_decoder_top.sv @@
// Self-checking testbench for the binaural FIR decoder top level.
`timescale 1ns / 1ps
module tb_multichannel_binaural_fir_decoder_top;
  import mbfd_pkg::*;

  localparam int  SEG_BEATS    = 110;
  localparam int  SETTLE       = 1200;     // three queued samples, each after a delay-line clear
  localparam longint CYCLE_CAP = 4000000;

  typedef enum int {ROW_BEAT, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e                  kind;
    cmd_e                       cmd;
    ear_e                       ear;
    logic [CH_W-1:0]            channel;
    logic [TAP_W-1:0]           tap;
    logic signed [SAMPLE_W-1:0] value;
    bit                         typed;
    logic signed [SAMPLE_W-1:0] ear_l;
    logic signed [SAMPLE_W-1:0] ear_r;
  } row_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } frame_out_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [FL_W-1:0]             cfg_data_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic                        cmd_i;
  logic                        ear_i;
  logic [CH_W-1:0]             channel_i;
  logic [TAP_W-1:0]            tap_i;
  logic signed [SAMPLE_W-1:0]  value_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [SAMPLE_W-1:0]  left_o;
  logic signed [SAMPLE_W-1:0]  right_o;

  multichannel_binaural_fir_decoder_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .ear_i      (ear_i),
    .channel_i  (channel_i),
    .tap_i      (tap_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .left_o     (left_o),
    .right_o    (right_o)
  );

  // Mirror of the decoder state, updated at every accepted input beat.
  logic signed [SAMPLE_W-1:0] hist_mem [CHANNELS][MAX_TAPS];
  logic signed [SAMPLE_W-1:0] coef_mem [2][CHANNELS][MAX_TAPS];
  bit                         coef_set [2][CHANNELS][MAX_TAPS];
  logic [ACC_W-1:0]           sum_l;
  logic [ACC_W-1:0]           sum_r;
  int                         wr_pos;
  int                         fir_len;

  frame_out_t frames_due[$];
  row_t       dir_rows[$];

  int     send_idle;
  int     recv_idle;
  int     hold_left;
  int     n_err;
  longint n_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Give up if the block hangs; count every clock.
  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void hist_clear();
    foreach (hist_mem[c, t]) hist_mem[c][t] = '0;
    wr_pos = 0;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] to_q15(logic [ACC_W-1:0] acc);
    longint s;
    longint q;
    s = longint'($signed(acc)) + 64'sd16384;
    q = s >>> (SAMPLE_W - 1);     // arithmetic shift floors toward minus infinity
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return SAMPLE_W'(q);
  endfunction

  // Apply one beat to the mirror; return 1 when it completes a frame.
  function automatic bit decode_beat(cmd_e cmd, ear_e ear, int ch, int tap,
                                     logic signed [SAMPLE_W-1:0] val,
                                     output frame_out_t res);
    int     taps;
    int     pos;
    longint x;
    taps = (fir_len > MAX_TAPS) ? MAX_TAPS : fir_len;
    res  = '{default: '0};
    if (cmd == CMD_COEF) begin
      coef_mem[ear][ch][tap] = val;
      coef_set[ear][ch][tap] = 1'b1;
      hist_clear();
      return 1'b0;
    end
    if (taps > 0) begin
      if (wr_pos >= taps) wr_pos = 0;
      pos = wr_pos;
      hist_mem[ch][pos] = val;
      for (int n = 0; n < taps; n++) begin
        x = hist_mem[ch][pos];
        sum_l = sum_l + ACC_W'(longint'(coef_mem[EAR_LEFT][ch][n]) * x);
        sum_r = sum_r + ACC_W'(longint'(coef_mem[EAR_RIGHT][ch][n]) * x);
        pos = (pos == 0) ? taps - 1 : pos - 1;
      end
    end
    if (ch != CHANNELS - 1) return 1'b0;
    res.left  = to_q15(sum_l);
    res.right = to_q15(sum_r);
    sum_l = '0;
    sum_r = '0;
    if (taps > 0) wr_pos = (wr_pos + 1) % taps;
    return 1'b1;
  endfunction

  // Offer one beat, with random idle cycles first; return once it is taken.
  task automatic offer_beat(row_t r);
    frame_out_t res;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= r.cmd;
    ear_i      <= r.ear;
    channel_i  <= r.channel;
    tap_i      <= r.tap;
    value_i    <= r.value;
    do @(posedge clk_i); while (in_stall_o);
    if (decode_beat(r.cmd, r.ear, r.channel, r.tap, r.value, res)) begin
      if (r.typed) begin
        res.left  = r.ear_l;
        res.right = r.ear_r;
      end
      frames_due.push_back(res);
    end
  endtask

  // Drain all frames, let the back finish silent work, then write filter_length.
  task automatic set_length(int len);
    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= FL_W'(len);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    fir_len = len;
    hist_clear();
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_value();
    case ($urandom_range(7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic row_t beat_row(cmd_e cmd, ear_e ear, int ch, int tap,
                                    logic signed [SAMPLE_W-1:0] val);
    row_t r;
    r = '{kind: ROW_BEAT, cmd: cmd, ear: ear, channel: ch, tap: tap, value: val,
          typed: 1'b0, ear_l: '0, ear_r: '0};
    return r;
  endfunction

  // Write every coefficient the coming filter length reads that is still unset.
  task automatic fill_coefs(int len);
    int taps;
    taps = (len > MAX_TAPS) ? MAX_TAPS : len;
    for (int e = 0; e < 2; e++)
      for (int c = 0; c < CHANNELS; c++)
        for (int t = 0; t < taps; t++)
          if (!coef_set[e][c][t]) offer_beat(beat_row(CMD_COEF, ear_e'(e), c, t, rand_value()));
  endtask

  task automatic add_row(row_kind_e kind, cmd_e cmd, ear_e ear, int ch, int tap, int val,
                         bit typed = 1'b0, int el = 0, int er = 0);
    row_t r;
    r = beat_row(cmd, ear, ch, tap, SAMPLE_W'(val));
    r.kind  = kind;
    r.typed = typed;
    r.ear_l = SAMPLE_W'(el);
    r.ear_r = SAMPLE_W'(er);
    dir_rows.push_back(r);
  endtask

  // Receiver: stall at random or through a long hold-off, and check each output beat.
  always @(posedge clk_i) begin
    frame_out_t want;
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle);
      end
      if (out_valid_o && !out_stall_i) begin
        if (frames_due.size() == 0) begin
          $error("output beat with nothing expected: left %0d right %0d", left_o, right_o);
          n_err++;
        end else begin
          want = frames_due.pop_front();
          if (left_o !== want.left) begin
            $error("left: expected %0d, got %0d", want.left, left_o);
            n_err++;
          end
          if (right_o !== want.right) begin
            $error("right: expected %0d, got %0d", want.right, right_o);
            n_err++;
          end
        end
      end
    end
  end

  initial begin
    int lens[4];
    int budget;
    int next_ch;
    int roll;
    row_t r;
    n_err      = 0;
    n_cycles   = 0;
    hold_left  = 0;
    send_idle  = 27;
    recv_idle  = 59;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    cmd_i      = 1'b0;
    ear_i      = 1'b0;
    channel_i  = '0;
    tap_i      = '0;
    value_i    = '0;
    out_stall_i = 1'b0;
    fir_len    = 0;
    sum_l      = '0;
    sum_r      = '0;
    hist_clear();
    foreach (coef_set[e, c, t]) begin
      coef_set[e][c][t] = 1'b0;
      coef_mem[e][c][t] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Length zero after reset: the frame still emits, and emits zero.
    add_row(ROW_BEAT, CMD_SAMPLE, EAR_RIGHT, 0, 255, 32767);
    add_row(ROW_BEAT, CMD_SAMPLE, EAR_LEFT, 1, 0, -32768);
    add_row(ROW_BEAT, CMD_SAMPLE, EAR_LEFT, 2, 0, 0);
    add_row(ROW_BEAT, CMD_SAMPLE, EAR_RIGHT, 3, 170, -1, 1'b1, 0, 0);
    // Tap 0 of every channel: left -1.0, right just under +1.0; top tap too.
    for (int c = 0; c < CHANNELS; c++) begin
      add_row(ROW_BEAT, CMD_COEF, EAR_LEFT, c, 0, -32768);
      add_row(ROW_BEAT, CMD_COEF, EAR_RIGHT, c, 0, 32767);
    end
    add_row(ROW_BEAT, CMD_COEF, EAR_RIGHT, 2, 255, 12345);
    add_row(ROW_CFG, CMD_SAMPLE, EAR_LEFT, 0, 0, 1);
    // Full-scale frames drive both ears into saturation, in both directions.
    for (int c = 0; c < CHANNELS; c++)
      add_row(ROW_BEAT, CMD_SAMPLE, EAR_LEFT, c, 0, -32768, c == CHANNELS - 1, 32767, -32768);
    for (int c = 0; c < CHANNELS; c++)
      add_row(ROW_BEAT, CMD_SAMPLE, EAR_LEFT, c, 0, 32767, c == CHANNELS - 1, -32768, 32767);
    // A coefficient beat mid-frame leaves the sums alone but clears history.
    add_row(ROW_BEAT, CMD_SAMPLE, EAR_LEFT, 0, 0, 1000);
    add_row(ROW_BEAT, CMD_COEF, EAR_LEFT, 1, 0, 4096);
    add_row(ROW_BEAT, CMD_SAMPLE, EAR_LEFT, 3, 0, -20000);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) set_length(dir_rows[i].value);
      else offer_beat(dir_rows[i]);
    end

    // Three idle mixes; each walks short, zero and longer filter lengths.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 27 : (phase == 1) ? 59 : 0;
      recv_idle = (phase == 0) ? 59 : (phase == 1) ? 27 : 0;
      lens[0] = 1 + $urandom_range(3);
      lens[1] = 32 + $urandom_range(31);
      lens[2] = 0;
      lens[3] = 4 + $urandom_range(12);
      foreach (lens[s]) begin
        fill_coefs(lens[s]);
        set_length(lens[s]);
        // Hold the output off long enough to back the input queue up.
        if (phase == 0 && s == 0) hold_left = 3000;
        budget  = SEG_BEATS;
        next_ch = 0;
        for (int k = 0; k < budget; k++) begin
          roll = $urandom_range(99);
          if (roll < 4) begin
            r = beat_row(CMD_COEF, ear_e'($urandom_range(1)), $urandom_range(CHANNELS - 1),
                         $urandom_range(MAX_TAPS - 1), rand_value());
          end else begin
            r = beat_row(CMD_SAMPLE, ear_e'($urandom_range(1)),
                         (roll < 9) ? $urandom_range(CHANNELS - 1) : next_ch,
                         $urandom_range(MAX_TAPS - 1), rand_value());
            next_ch = (r.channel + 1) % CHANNELS;
          end
          offer_beat(r);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (n_err == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/mbfd_pkg.sv
src/mbfd_ram.sv
src/mbfd_front.sv
src/mbfd_back.sv
src/multichannel_binaural_fir_decoder_top.sv
bench/tb_multichannel_binaural_fir_decoder_top.sv
